FILE: src/binary_min_heap_queue_defines.svh
// Assertion macros for the heap queue. Each expands to one labelled
// concurrent assertion clocked on clk and held off during rst.
`ifndef BINARY_MIN_HEAP_QUEUE_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_DEFINES_SVH

// same-cycle implication
`define BMHQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BMHQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/bmhq_pkg.sv
package bmhq_pkg;

  localparam int CAPACITY    = 64;
  localparam int ADDR_W      = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int KEY_W       = 32;
  localparam int COUNT_OUT_W = 7;
  localparam int OUT_DATA_W  = 72;
  localparam int OUT_USER_W  = 2;

  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

  localparam logic MODE_INSERT  = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_CHK,
    ST_UP_CMP,
    ST_DN_LAST,
    ST_DN_RD,
    ST_DN_CMP,
    ST_FIN
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic flag_full;    // refused insert
    logic flag_empty;   // extract on empty heap
    logic ins_begin;    // hole at end, count up
    logic ext_begin;    // capture root, count down, read last entry
    logic load_last;    // moving key := last entry
    logic rd_parent;
    logic up_step;      // parent moves down into hole
    logic rd_children;
    logic down_step;    // smaller child moves up into hole
    logic wr_hold;      // moving key lands in hole
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic pos_zero;
    logic up_less;
    logic down_move;
    logic out_free;
  } stat_t;

endpackage

FILE: src/bmhq_ctrl.sv
module bmhq_ctrl
  import bmhq_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  input  logic  in_mode,
  input  stat_t stat,
  output logic  s_tready,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (in_mode == MODE_INSERT) begin
            state_next = stat.cnt_full ? ST_FIN : ST_UP_CHK;
          end else begin
            state_next = stat.cnt_zero ? ST_FIN : ST_DN_LAST;
          end
        end
      end
      ST_UP_CHK:  state_next = stat.pos_zero ? ST_FIN : ST_UP_CMP;
      ST_UP_CMP:  state_next = stat.up_less ? ST_UP_CHK : ST_FIN;
      ST_DN_LAST: state_next = stat.cnt_zero ? ST_FIN : ST_DN_RD;
      ST_DN_RD:   state_next = ST_DN_CMP;
      ST_DN_CMP:  state_next = stat.down_move ? ST_DN_RD : ST_FIN;
      ST_FIN:     state_next = stat.out_free ? ST_IDLE : ST_FIN;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (in_mode == MODE_INSERT) begin
            cmd.flag_full = stat.cnt_full;
            cmd.ins_begin = !stat.cnt_full;
          end else begin
            cmd.flag_empty = stat.cnt_zero;
            cmd.ext_begin  = !stat.cnt_zero;
          end
        end
      end
      ST_UP_CHK: begin
        cmd.wr_hold   = stat.pos_zero;
        cmd.rd_parent = !stat.pos_zero;
      end
      ST_UP_CMP: begin
        cmd.up_step = stat.up_less;
        cmd.wr_hold = !stat.up_less;
      end
      ST_DN_LAST: cmd.load_last   = !stat.cnt_zero;
      ST_DN_RD:   cmd.rd_children = 1'b1;
      ST_DN_CMP: begin
        cmd.down_step = stat.down_move;
        cmd.wr_hold   = !stat.down_move;
      end
      ST_FIN:  cmd.out_load = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

FILE: src/bmhq_datapath.sv
module bmhq_datapath
  import bmhq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    cmd,
  input  logic signed [KEY_W-1:0] in_key,
  input  logic                    m_tready,
  output stat_t                   stat,
  output logic                    m_tvalid,
  output logic [OUT_DATA_W-1:0]   m_tdata,
  output logic [OUT_USER_W-1:0]   m_tuser
);

  logic signed [KEY_W-1:0] heap_mem [CAPACITY];

  logic [CNT_W-1:0]        count;
  logic [ADDR_W-1:0]       pos;
  logic signed [KEY_W-1:0] hold;
  logic signed [KEY_W-1:0] root_key;
  logic signed [KEY_W-1:0] extracted;
  logic                    res_empty;
  logic                    res_full;
  logic signed [KEY_W-1:0] rd_a;
  logic signed [KEY_W-1:0] rd_b;

  logic [ADDR_W-1:0]       parent;
  logic [ADDR_W:0]         lc_full;
  logic [ADDR_W+1:0]       rc_full;
  logic                    lc_ok, rc_ok, l_win, r_win;
  logic signed [KEY_W-1:0] l_best;
  logic [ADDR_W-1:0]       best_addr;
  logic signed [KEY_W-1:0] best_val;
  logic [ADDR_W-1:0]       ra_addr, rb_addr, wr_addr;
  logic signed [KEY_W-1:0] wr_data;
  logic                    wr_en;
  logic [CNT_W-1:0]        count_dec;
  logic signed [KEY_W-1:0] cur_min;

  // tree links
  assign parent  = ADDR_W'((pos - ADDR_W'(1)) >> 1);
  assign lc_full = {pos, 1'b1};
  assign rc_full = {1'b0, pos, 1'b0} + (ADDR_W+2)'(2);
  assign lc_ok   = lc_full < count;
  assign rc_ok   = rc_full < (ADDR_W+2)'(count);

  // left wins only on strictly smaller; right must beat the running best
  assign l_win     = lc_ok && (rd_a < hold);
  assign l_best    = l_win ? rd_a : hold;
  assign r_win     = rc_ok && (rd_b < l_best);
  assign best_addr = r_win ? rc_full[ADDR_W-1:0] : lc_full[ADDR_W-1:0];
  assign best_val  = r_win ? rd_b : rd_a;

  assign count_dec = count - CNT_W'(1);

  always_comb begin
    ra_addr = lc_full[ADDR_W-1:0];
    if (cmd.ext_begin) begin
      ra_addr = count_dec[ADDR_W-1:0];
    end else if (cmd.rd_parent) begin
      ra_addr = parent;
    end
  end
  assign rb_addr = rc_full[ADDR_W-1:0];

  always_comb begin
    wr_en   = cmd.up_step | cmd.down_step | cmd.wr_hold;
    wr_addr = pos;
    wr_data = hold;
    if (cmd.up_step) begin
      wr_data = rd_a;
    end else if (cmd.down_step) begin
      wr_data = best_val;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      heap_mem[wr_addr] <= wr_data;
    end
    rd_a <= heap_mem[ra_addr];
    rd_b <= heap_mem[rb_addr];
  end

  // shadow copy of the root, kept by watching writes to slot zero
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == '0)) begin
      root_key <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.ins_begin) begin
      count <= count + CNT_W'(1);
    end else if (cmd.ext_begin) begin
      count <= count_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_begin | cmd.ext_begin | cmd.flag_full | cmd.flag_empty) begin
      extracted <= cmd.ext_begin ? root_key : KEY_MAX;
      res_empty <= cmd.flag_empty;
      res_full  <= cmd.flag_full;
    end
    if (cmd.ins_begin) begin
      hold <= in_key;
      pos  <= count[ADDR_W-1:0];
    end else if (cmd.ext_begin) begin
      pos <= '0;
    end else if (cmd.load_last) begin
      hold <= rd_a;
    end else if (cmd.up_step) begin
      pos <= parent;
    end else if (cmd.down_step) begin
      pos <= best_addr;
    end
  end

  assign cur_min = (count == '0) ? KEY_MAX : root_key;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {1'b0, COUNT_OUT_W'(count), cur_min, extracted};
      m_tuser <= {res_full, res_empty};
    end
  end

  assign stat.cnt_zero  = (count == '0);
  assign stat.cnt_full  = (count >= CNT_W'(CAPACITY));
  assign stat.pos_zero  = (pos == '0);
  assign stat.up_less   = (hold < rd_a);
  assign stat.down_move = l_win | r_win;
  assign stat.out_free  = !m_tvalid | m_tready;

endmodule

FILE: src/binary_min_heap_queue.sv
// Binary min-heap priority queue of signed 32-bit keys, up to 64 entries.
// Each input transaction is an insert (tuser = 0) or an extract-min
// (tuser = 1) and produces exactly one output transaction carrying the
// removed key, the empty/full flags, the new minimum and the entry count.
// One request is in flight at a time. Each level of a sift reads a parent
// or a child pair from the heap RAM, then compares and writes back; an
// insert key moves at most 6 levels and an extract key at most 5. An
// extract that leaves entries fetches the last entry first and ends on a
// child compare. A refused insert or an empty extract goes straight to the
// output stage. The load of the output register waits while an earlier
// result is still held there by m_tready. A result waits in the output
// register while the next request is already being taken. Keys equal to
// their parent stay put; on the way down the left child wins a tie. No RAM
// clearing is done after reset: only values from slots below the count are
// ever used.
`include "binary_min_heap_queue_defines.svh"

module binary_min_heap_queue
  import bmhq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [KEY_W-1:0]      s_tdata,   // [31:0] key_value
  input  logic                  s_tuser,   // [0] mode
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [31:0] extracted_value, [63:32] current_min,
                                           // [70:64] entry_count, [71] zero
  output logic [OUT_USER_W-1:0] m_tuser    // [0] was_empty, [1] was_full
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer: walks the sift up/down one level at a time, a read state then a compare state
  bmhq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .in_mode  (s_tuser),
    .stat     (stat),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  // heap RAM, count, moving key and output register
  bmhq_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_key   ($signed(s_tdata)),
    .m_tready (m_tready),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // one transaction in flight: ready drops right after an accept
  `BMHQ_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second request taken while busy")
  // count never passes capacity
  `BMHQ_ASSERT_NOW(a_count_cap, m_tvalid, m_tdata[70:64] <= COUNT_OUT_W'(CAPACITY), "entry count above capacity")
  // empty extract reports the largest key
  `BMHQ_ASSERT_NOW(a_empty_value, m_tvalid && m_tuser[0], m_tdata[31:0] == KEY_MAX, "empty extract value wrong")
  // an empty heap shows the largest key as minimum
  `BMHQ_ASSERT_NOW(a_empty_min, m_tvalid && (m_tdata[70:64] == '0), m_tdata[63:32] == KEY_MAX, "minimum of empty heap wrong")

endmodule
